>>> hw/rtl/uqpd_pkg.sv
package uqpd_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX  = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] char_in;
        logic       char_valid;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       in_value_part;
        logic       pair_done;
        logic       query_done;
        logic       run_last;
    } t_out_item;

    // All results caused by one input item, oldest in slot 0.
    typedef struct packed {
        t_out_item [MAX_RESULTS-1:0] items;
        logic [CNT_W-1:0]            count;
    } t_batch;

    function automatic logic hex_valid(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Only meaningful for a valid hex digit of either case.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= CH_NINE) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic t_out_item mk_item(input logic [7:0] b, input logic bv,
                                          input logic vp, input logic pd,
                                          input logic qd);
        t_out_item it;
        it.byte_out      = b;
        it.byte_valid    = bv;
        it.in_value_part = vp;
        it.pair_done     = pd;
        it.query_done    = qd;
        it.run_last      = 1'b0;
        return it;
    endfunction

endpackage

>>> hw/rtl/uqpd_decode.sv
module uqpd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_accept,
    input  uqpd_pkg::t_in_item i_item,
    output uqpd_pkg::t_batch  o_batch
);

    uqpd_pkg::t_esc r_esc, n_esc;
    logic [7:0]     r_held, n_held;
    logic           r_vp, n_vp;
    logic           r_plus;

    uqpd_pkg::t_out_item [uqpd_pkg::MAX_RESULTS-1:0] n_items;
    logic [uqpd_pkg::CNT_W-1:0]                       n_cnt;
    logic [uqpd_pkg::IDX_W-1:0]                       n_last;
    logic                                             c_hex;
    logic [7:0]                                       c;

    assign c     = i_item.char_in;
    assign c_hex = uqpd_pkg::hex_valid(c);

    // The results of one item are laid out in order; n_cnt is the next free slot.
    always_comb begin
        n_esc   = r_esc;
        n_held  = r_held;
        n_vp    = r_vp;
        n_cnt   = '0;
        n_items = '0;
        n_last  = '0;

        if (i_item.char_valid) begin
            if (r_esc == uqpd_pkg::ESC_PCT && c_hex) begin
                n_esc  = uqpd_pkg::ESC_HEX;
                n_held = c;
            end else if (r_esc == uqpd_pkg::ESC_HEX && c_hex) begin
                n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                    {uqpd_pkg::hex_nibble(r_held), uqpd_pkg::hex_nibble(c)},
                    1'b1, n_vp, 1'b0, 1'b0);
                n_cnt  = n_cnt + uqpd_pkg::CNT_ONE;
                n_esc  = uqpd_pkg::ESC_NONE;
                n_held = '0;
            end else begin
                // A broken escape is passed through literally, then the byte is
                // taken afresh.
                if (n_esc != uqpd_pkg::ESC_NONE) begin
                    n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                        uqpd_pkg::CH_PERCENT, 1'b1, n_vp, 1'b0, 1'b0);
                    n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
                end
                if (n_esc == uqpd_pkg::ESC_HEX) begin
                    n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                        n_held, 1'b1, n_vp, 1'b0, 1'b0);
                    n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
                end
                n_esc  = uqpd_pkg::ESC_NONE;
                n_held = '0;

                if (c == uqpd_pkg::CH_AMP) begin
                    n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                        8'h00, 1'b0, n_vp, 1'b1, 1'b0);
                    n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
                    n_vp  = 1'b0;
                end else if (c == uqpd_pkg::CH_EQUALS && !n_vp) begin
                    n_vp = 1'b1;
                end else if (c == uqpd_pkg::CH_PERCENT) begin
                    n_esc = uqpd_pkg::ESC_PCT;
                end else if (c == uqpd_pkg::CH_PLUS && r_plus) begin
                    n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                        uqpd_pkg::CH_SPACE, 1'b1, n_vp, 1'b0, 1'b0);
                    n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
                end else begin
                    n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                        c, 1'b1, n_vp, 1'b0, 1'b0);
                    n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
                end
            end
        end

        if (i_item.string_end) begin
            if (n_esc != uqpd_pkg::ESC_NONE) begin
                n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                    uqpd_pkg::CH_PERCENT, 1'b1, n_vp, 1'b0, 1'b0);
                n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
            end
            if (n_esc == uqpd_pkg::ESC_HEX) begin
                n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                    n_held, 1'b1, n_vp, 1'b0, 1'b0);
                n_cnt = n_cnt + uqpd_pkg::CNT_ONE;
            end
            n_items[n_cnt[uqpd_pkg::IDX_W-1:0]] = uqpd_pkg::mk_item(
                8'h00, 1'b0, n_vp, 1'b1, 1'b1);
            n_cnt  = n_cnt + uqpd_pkg::CNT_ONE;
            n_esc  = uqpd_pkg::ESC_NONE;
            n_held = '0;
            n_vp   = 1'b0;
        end

        if (n_cnt != '0) begin
            n_last = n_cnt[uqpd_pkg::IDX_W-1:0] - uqpd_pkg::IDX_ONE;
            n_items[n_last].run_last = 1'b1;
        end
    end

    assign o_batch.items = n_items;
    assign o_batch.count = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= uqpd_pkg::ESC_NONE;
            r_held <= '0;
            r_vp   <= 1'b0;
            r_plus <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_plus <= i_cfg_data;
            end
            if (i_accept) begin
                r_esc  <= n_esc;
                r_held <= n_held;
                r_vp   <= n_vp;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_held_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc == uqpd_pkg::ESC_HEX |-> uqpd_pkg::hex_valid(r_held))
        else $error("held escape digit is not a hex digit");

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != uqpd_pkg::ESC_HEX |-> r_held == 8'h00)
        else $error("held digit not cleared outside a two-digit escape");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.string_end
        |=> r_esc == uqpd_pkg::ESC_NONE && !r_vp)
        else $error("state not cleared after string end");
`endif

endmodule

>>> hw/rtl/uqpd_emit.sv
module uqpd_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  uqpd_pkg::t_batch    i_batch,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output uqpd_pkg::t_out_item o_item
);

    uqpd_pkg::t_out_item [uqpd_pkg::MAX_RESULTS-1:0] r_items;
    logic [uqpd_pkg::CNT_W-1:0]                       r_rem;
    logic [uqpd_pkg::IDX_W-1:0]                       r_idx;
    logic                                             out_fire;

    assign o_valid    = (r_rem != '0);
    assign o_item     = r_items[r_idx];
    assign out_fire   = o_valid && i_ready;
    // A new batch may enter as the last pending result leaves.
    assign o_can_load = (r_rem == '0) || ((r_rem == uqpd_pkg::CNT_ONE) && i_ready);

    always_ff @(posedge i_clk) begin
        if (i_load && i_batch.count != '0) begin
            r_items <= i_batch.items;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (i_load && i_batch.count != '0) begin
            r_rem <= i_batch.count;
            r_idx <= '0;
        end else if (out_fire) begin
            r_rem <= r_rem - uqpd_pkg::CNT_ONE;
            r_idx <= r_idx + uqpd_pkg::IDX_ONE;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_rem == '0) || (r_rem == uqpd_pkg::CNT_ONE && out_fire))
        else $error("batch loaded over pending results");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.run_last |-> r_rem == uqpd_pkg::CNT_ONE)
        else $error("run_last seen before the final result of an item");
`endif

endmodule

>>> hw/rtl/url_query_pair_decoder.sv
// Streaming query-string decoder. Raw bytes enter on the input channel
// (i_in_valid / o_in_ready / i_in_item); decoded bytes and pair markers leave
// on the output channel (o_out_valid / i_out_ready / o_out_item), each item
// tagged name or value, with pair_done at '&' and at string end, query_done on
// the final result of the string and run_last on the last result of an input.
// The plus_to_space register is written through i_cfg_valid / i_cfg_data;
// o_cfg_ready is always high. Write it only while the block is idle.
// The first result of an item is presented the cycle after it is
// accepted. An item causes at most 4 results; ordinary bytes and escape
// digits flow at one item per cycle while the output is not stalled. The
// single result buffer takes a new batch as its last pending result is taken.
// Reset (synchronous, active low) empties the result buffer, clears the
// escape and name/value state and sets plus_to_space to 1. When the receiver
// stalls, the current result holds steady and o_in_ready stays low while any
// result is waiting; it follows i_out_ready once only the last one is left.
module url_query_pair_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  uqpd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output uqpd_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    uqpd_pkg::t_batch batch;
    logic             in_fire;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    uqpd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_fire),
        .i_item     (i_in_item),
        .o_batch    (batch)
    );

    uqpd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_batch    (batch),
        .o_can_load (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule
